// ===== src/ttb_pkg.sv =====
package ttb_pkg;

    localparam int InFracBits  = 16;
    localparam int OutFracBits = 14;

    // Tiny-value threshold in product format, rounded, at least one.
    localparam longint EpsRaw = longint'(((64'd1 << (2 * InFracBits)) + 64'd500000) / 64'd1000000);
    localparam logic signed [63:0] Eps = (EpsRaw < 1) ? 64'sd1 : 64'(EpsRaw);

    localparam logic signed [32:0] EdgeMax = 33'sd2147483647;

    // Operation codes for the shared arithmetic unit.
    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQRT,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic        start;
        t_op         op;
        logic [63:0] a;
        logic [63:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] res;
    } t_alu_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_EDGE,
        S_MUL,
        S_MULW,
        S_COMB,
        S_CLAMP,
        S_NSTART,
        S_NMAX,
        S_NSHR,
        S_NSHL,
        S_NSQ,
        S_NSQW,
        S_NSQRT,
        S_NSQRTW,
        S_NDIV,
        S_NDIVW,
        S_NSTORE,
        S_OUT
    } t_state;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [31:0] edge_sat(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        if (d > EdgeMax) edge_sat = 32'sh7fffffff;
        else if (d < -EdgeMax) edge_sat = -32'sh7fffffff;
        else edge_sat = d[31:0];
    endfunction

endpackage

// ===== src/triangle_tangent_binormal_unit.sv =====
// Vertices one and two of a triangle are stored and give no word.
// Vertex three starts a sequencer around one shared unit (32x32 multiply, square root
// and 64-bit divide): the output word follows the two square roots, six divides and
// the normalizing shifts. No new vertex is taken until the output word has been taken.
// Synchronous active-low reset clears the vertex count and the sequencer.
module triangle_tangent_binormal_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z
    output logic [95:0]  m_axis_tdata
);
    import ttb_pkg::*;

    t_state r_state, n_state;
    logic [1:0] r_vcnt;
    logic signed [31:0] r_hp [6];
    logic signed [31:0] r_ht [4];
    logic signed [31:0] r_cp [3];
    logic signed [31:0] r_cu, r_cv;

    // Edges: e1 x,y,z, e2 x,y,z, s1, t1, s2, t2
    logic signed [31:0] r_e [10];
    // Products: s1t2, t1s2, then per k: t1e2, e1t2, e1s2, s1e2
    logic signed [63:0] r_p [14];
    logic [3:0] r_pi;
    logic signed [63:0] r_det;
    logic signed [63:0] r_vec [6];

    // Normalizer state
    logic       r_vi;        // 0 tangent, 1 binormal
    logic [1:0] r_k;
    logic [63:0] r_w [3];
    logic [63:0] r_m;
    logic [63:0] r_sum;
    logic [63:0] r_len;
    logic [15:0] r_res [6];
    logic        r_neg;

    // First component of the vector being normalized.
    logic [2:0] vbase;
    assign vbase = r_vi ? 3'd3 : 3'd0;

    t_alu_req alu_req;
    t_alu_rsp alu_rsp;

    ttb_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .o_rsp  (alu_rsp)
    );

    logic in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Operand pairs for the product sequence.
    logic signed [31:0] pa, pb;
    always_comb begin
        pa = r_e[6];
        pb = r_e[9];
        unique case (r_pi)
            4'd0: begin pa = r_e[6]; pb = r_e[9]; end
            4'd1: begin pa = r_e[7]; pb = r_e[8]; end
            4'd2: begin pa = r_e[7]; pb = r_e[3]; end
            4'd3: begin pa = r_e[0]; pb = r_e[9]; end
            4'd4: begin pa = r_e[0]; pb = r_e[8]; end
            4'd5: begin pa = r_e[6]; pb = r_e[3]; end
            4'd6: begin pa = r_e[7]; pb = r_e[4]; end
            4'd7: begin pa = r_e[1]; pb = r_e[9]; end
            4'd8: begin pa = r_e[1]; pb = r_e[8]; end
            4'd9: begin pa = r_e[6]; pb = r_e[4]; end
            4'd10: begin pa = r_e[7]; pb = r_e[5]; end
            4'd11: begin pa = r_e[2]; pb = r_e[9]; end
            4'd12: begin pa = r_e[2]; pb = r_e[8]; end
            4'd13: begin pa = r_e[6]; pb = r_e[5]; end
            default: begin pa = r_e[6]; pb = r_e[9]; end
        endcase
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_fire && r_vcnt == 2'd2) n_state = S_EDGE;
            S_EDGE:   n_state = S_MUL;
            S_MUL:    n_state = S_MULW;
            S_MULW:   if (alu_rsp.done) n_state = (r_pi == 4'd13) ? S_COMB : S_MUL;
            S_COMB:   n_state = S_CLAMP;
            S_CLAMP:  n_state = S_NSTART;
            S_NSTART: n_state = S_NMAX;
            S_NMAX:   n_state = (r_m == 64'd0) ? S_NSTORE : S_NSHR;
            S_NSHR:   if (r_m < (64'd1 << 30)) n_state = S_NSHL;
            S_NSHL:   if (r_m >= (64'd1 << 29)) n_state = S_NSQ;
            S_NSQ:    n_state = S_NSQW;
            S_NSQW:   if (alu_rsp.done) n_state = (r_k == 2'd2) ? S_NSQRT : S_NSQ;
            S_NSQRT:  n_state = S_NSQRTW;
            S_NSQRTW: if (alu_rsp.done) n_state = S_NDIV;
            S_NDIV:   n_state = S_NDIVW;
            S_NDIVW:  if (alu_rsp.done) n_state = (r_k == 2'd2) ? S_NSTORE : S_NDIV;
            S_NSTORE: n_state = r_vi ? S_OUT : S_NSTART;
            S_OUT:    if (m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Output and unit request logic.
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_OUT);
        alu_req.start = 1'b0;
        alu_req.op    = OP_MUL;
        alu_req.a     = 64'd0;
        alu_req.b     = 64'd0;
        unique case (r_state)
            S_MUL: begin
                alu_req.start = 1'b1;
                alu_req.a = 64'($unsigned(pa));
                alu_req.b = 64'($unsigned(pb));
            end
            S_NSQ: begin
                alu_req.start = 1'b1;
                alu_req.a = {32'd0, r_w[r_k][31:0]};
                alu_req.b = {32'd0, r_w[r_k][31:0]};
            end
            S_NSQRT: begin
                alu_req.start = 1'b1;
                alu_req.op = OP_SQRT;
                alu_req.a = r_sum;
            end
            S_NDIV: begin
                alu_req.start = 1'b1;
                alu_req.op = OP_DIV;
                alu_req.a = (r_w[r_k] << OutFracBits) + (r_len >> 1);
                alu_req.b = r_len;
            end
            default: begin
                alu_req.start = 1'b0;
            end
        endcase
    end

    logic [63:0] va [3];
    logic        bt, ct;
    always_comb begin
        for (int k = 0; k < 3; k++) va[k] = mag64(r_vec[vbase + 3'(k)]);
        bt = 1'b1;
        ct = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (mag64(r_vec[k]) >= 64'(Eps)) bt = 1'b0;
            if (mag64(r_vec[3 + k]) >= 64'(Eps)) ct = 1'b0;
        end
    end

    logic [63:0] q_sat;
    logic        sgn;
    logic [16:0] qm;
    logic signed [17:0] rs;
    always_comb begin
        q_sat = (alu_rsp.res > 64'd32768) ? 64'd32768 : alu_rsp.res;
        qm    = q_sat[16:0];
        sgn   = r_vec[vbase + 3'(r_k)][63] != r_neg;
        rs    = sgn ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        if (rs > 18'sd32767) rs = 18'sd32767;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcnt  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (in_fire) r_vcnt <= (r_vcnt == 2'd1) ? 2'd2 : (r_vcnt == 2'd2) ? 2'd0 : 2'd1;
        end

        // Hold the vertices.
        if (in_fire) begin
            if (r_vcnt == 2'd1) begin
                r_hp[3] <= s_axis_tdata[31:0];
                r_hp[4] <= s_axis_tdata[63:32];
                r_hp[5] <= s_axis_tdata[95:64];
                r_ht[2] <= s_axis_tdata[127:96];
                r_ht[3] <= s_axis_tdata[159:128];
            end else if (r_vcnt == 2'd2) begin
                r_cp[0] <= s_axis_tdata[31:0];
                r_cp[1] <= s_axis_tdata[63:32];
                r_cp[2] <= s_axis_tdata[95:64];
                r_cu    <= s_axis_tdata[127:96];
                r_cv    <= s_axis_tdata[159:128];
            end else begin
                r_hp[0] <= s_axis_tdata[31:0];
                r_hp[1] <= s_axis_tdata[63:32];
                r_hp[2] <= s_axis_tdata[95:64];
                r_ht[0] <= s_axis_tdata[127:96];
                r_ht[1] <= s_axis_tdata[159:128];
            end
        end

        unique case (r_state)
            S_EDGE: begin
                for (int k = 0; k < 3; k++) begin
                    r_e[k]     <= edge_sat(r_hp[k], r_hp[3 + k]);
                    r_e[3 + k] <= edge_sat(r_hp[k], r_cp[k]);
                end
                r_e[6] <= edge_sat(r_ht[0], r_ht[2]);
                r_e[7] <= edge_sat(r_ht[1], r_ht[3]);
                r_e[8] <= edge_sat(r_ht[0], r_cu);
                r_e[9] <= edge_sat(r_ht[1], r_cv);
                r_pi <= 4'd0;
            end
            S_MULW: begin
                if (alu_rsp.done) begin
                    r_p[r_pi] <= $signed(alu_rsp.res);
                    r_pi <= r_pi + 4'd1;
                end
            end
            S_COMB: begin
                r_det <= r_p[0] - r_p[1];
                for (int k = 0; k < 3; k++) begin
                    r_vec[k]     <= r_p[2 + 4 * k] - r_p[3 + 4 * k];
                    r_vec[3 + k] <= r_p[4 + 4 * k] - r_p[5 + 4 * k];
                end
            end
            S_CLAMP: begin
                // A tiny determinant becomes positive epsilon.
                r_neg <= (mag64(r_det) < 64'(Eps)) ? 1'b1 : (r_det > 64'sd0);
                for (int k = 0; k < 3; k++) begin
                    if (bt) r_vec[k] <= Eps;
                    if (ct) r_vec[3 + k] <= Eps;
                end
                r_vi <= 1'b0;
            end
            S_NSTART: begin
                r_w[0] <= va[0];
                r_w[1] <= va[1];
                r_w[2] <= va[2];
                r_m <= (va[0] > va[1]) ? ((va[0] > va[2]) ? va[0] : va[2])
                                       : ((va[1] > va[2]) ? va[1] : va[2]);
                r_k <= 2'd0;
            end
            S_NMAX: begin
                if (r_m == 64'd0) begin
                    for (int k = 0; k < 3; k++) r_res[vbase + 3'(k)] <= 16'd0;
                end
            end
            S_NSHR: begin
                if (r_m >= (64'd1 << 30)) begin
                    r_m <= r_m >> 1;
                    for (int k = 0; k < 3; k++) r_w[k] <= r_w[k] >> 1;
                end
                r_sum <= 64'd0;
            end
            S_NSHL: begin
                if (r_m < (64'd1 << 29)) begin
                    r_m <= r_m << 1;
                    for (int k = 0; k < 3; k++) r_w[k] <= r_w[k] << 1;
                end
            end
            S_NSQW: begin
                if (alu_rsp.done) begin
                    r_sum <= r_sum + alu_rsp.res;
                    r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                end
            end
            S_NSQRTW: begin
                if (alu_rsp.done) r_len <= alu_rsp.res;
            end
            S_NDIVW: begin
                if (alu_rsp.done) begin
                    r_res[vbase + 3'(r_k)] <= rs[15:0];
                    r_k <= r_k + 2'd1;
                end
            end
            S_NSTORE: begin
                r_vi <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tdata = {r_res[5], r_res[4], r_res[3], r_res[2], r_res[1], r_res[0]};

    // Input is only taken while nothing is in flight.
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
    a_third_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_vcnt == 2'd2) |=> r_state == S_EDGE) else $error("no start");
    a_vcnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vcnt != 2'd3) else $error("vertex count out of range");

endmodule

// ===== src/ttb_alu.sv =====
module ttb_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ttb_pkg::t_alu_req i_req,
    output ttb_pkg::t_alu_rsp o_rsp
);
    import ttb_pkg::*;

    logic        r_busy, n_busy;
    t_op         r_op, n_op;
    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_a, n_a;
    logic [63:0] r_b, n_b;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_rem, n_rem;
    logic        r_done, n_done;

    logic [64:0] sq_trial;
    logic [64:0] div_trial;
    logic [63:0] div_rem_sh;
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    logic signed [63:0] mul_p;

    // Signed 32x32 product in one step, square root and division one bit a cycle.
    // The operands are the sign-extended low words, so the low 64 bits of the
    // product are the full 32x32 result.
    assign mul_a      = {{32{r_a[31]}}, r_a[31:0]};
    assign mul_b      = {{32{r_b[31]}}, r_b[31:0]};
    assign mul_p      = mul_a * mul_b;
    assign sq_trial   = {1'b0, r_rem} - {1'b0, r_acc | r_b};
    assign div_rem_sh = {r_rem[62:0], r_a[63]};
    assign div_trial  = {1'b0, div_rem_sh} - {1'b0, r_b};

    always_comb begin
        n_busy = r_busy;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_acc  = r_acc;
        n_rem  = r_rem;
        n_done = 1'b0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_a    = i_req.a;
            n_b    = (i_req.op == OP_SQRT) ? (64'd1 << 62) : i_req.b;
            n_rem  = (i_req.op == OP_SQRT) ? i_req.a : 64'd0;
            n_acc  = 64'd0;
            n_cnt  = (i_req.op == OP_DIV) ? 7'd64 : (i_req.op == OP_SQRT) ? 7'd32 : 7'd1;
        end else if (r_busy) begin
            unique case (r_op)
                OP_MUL: begin
                    n_acc = 64'(mul_p);
                end
                OP_SQRT: begin
                    if (!sq_trial[64]) begin
                        n_rem = sq_trial[63:0];
                        n_acc = (r_acc >> 1) + r_b;
                    end else begin
                        n_acc = r_acc >> 1;
                    end
                    n_b = r_b >> 2;
                end
                OP_DIV: begin
                    n_a = {r_a[62:0], 1'b0};
                    if (!div_trial[64]) begin
                        n_rem = div_trial[63:0];
                        n_acc = {r_acc[62:0], 1'b1};
                    end else begin
                        n_rem = div_rem_sh;
                        n_acc = {r_acc[62:0], 1'b0};
                    end
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
            r_cnt  <= 7'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_acc <= n_acc;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc;

    // A finished operation never coincides with a still-running one.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("alu done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy) else $error("alu did not start");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != 7'd0) else $error("alu count ran out");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ttb_pkg::*;

    typedef struct packed {
        logic signed [31:0] tex_v;
        logic signed [31:0] tex_u;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } t_vertex;

    typedef struct {
        t_vertex     vtx;
        bit          typed;
        logic [95:0] word;
    } t_row;

    localparam logic signed [31:0] PMax = 32'sh7fffffff;
    localparam logic signed [31:0] NMax = 32'sh80000000;
    localparam int NumRandTris = 200;
    localparam int TailCycles = 700;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // pos_x, pos_y, pos_z, tex_u, tex_v
    logic [159:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z
    logic [95:0]  m_axis_tdata;

    triangle_tangent_binormal_unit dut (.*);

    // Predictor state: the two held corners and how many are held.
    longint      corner_pos[6];
    longint      corner_uv[4];
    int          corners_held;
    logic [95:0] pending_frames[$];
    int          errors;
    int          frames_seen;
    int          vertices_sent;
    bit          no_stall;
    t_row        plan[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_top failed");
        $finish;
    end

    function automatic longint clip_edge(longint a, longint b);
        longint d;
        d = a - b;
        if (d > 64'sd2147483647) return 64'sd2147483647;
        if (d < -64'sd2147483647) return -64'sd2147483647;
        return d;
    endfunction

    function automatic logic [63:0] abs64(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // Scale a vector to a unit vector in Q1.14, negated when flip is set.
    function automatic logic [47:0] unit_dir(longint v0, longint v1, longint v2, bit flip);
        logic [63:0] w[3];
        bit          neg_k[3];
        longint      v[3];
        logic [63:0] m, sum, len, rem, bitv, q;
        longint      r;
        logic [47:0] res;
        v[0] = v0; v[1] = v1; v[2] = v2;
        m = 0;
        res = '0;
        for (int k = 0; k < 3; k++) begin
            w[k] = abs64(v[k]);
            neg_k[k] = (v[k] < 0) != flip;
            if (w[k] > m) m = w[k];
        end
        if (m == 0) return '0;
        while (m >= (64'd1 << 30)) begin
            m = m >> 1;
            for (int k = 0; k < 3; k++) w[k] = w[k] >> 1;
        end
        while (m < (64'd1 << 29)) begin
            m = m << 1;
            for (int k = 0; k < 3; k++) w[k] = w[k] << 1;
        end
        sum = 0;
        for (int k = 0; k < 3; k++) sum += w[k] * w[k];
        // Integer square root, two bits a step.
        rem = sum;
        len = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= len + bitv) begin
                rem = rem - (len + bitv);
                len = (len >> 1) + bitv;
            end else begin
                len = len >> 1;
            end
            bitv = bitv >> 2;
        end
        for (int k = 0; k < 3; k++) begin
            q = ((w[k] << OutFracBits) + (len >> 1)) / len;
            if (q > 64'd32768) q = 64'd32768;
            r = neg_k[k] ? -longint'(q) : longint'(q);
            if (r > 32767) r = 32767;
            res[16*k +: 16] = r[15:0];
        end
        return res;
    endfunction

    // Advance the vertex counter; on the third corner compute the frame word.
    function automatic bit frame_predict(t_vertex vx, output logic [95:0] word);
        longint p[3], e1[3], e2[3], bv[3], cv[3];
        longint s1, t1, s2, t2, det, eps;
        bit     b_tiny, c_tiny;
        p[0] = vx.pos_x; p[1] = vx.pos_y; p[2] = vx.pos_z;
        eps = Eps;
        word = '0;
        if (corners_held == 1) begin
            for (int k = 0; k < 3; k++) corner_pos[3+k] = p[k];
            corner_uv[2] = vx.tex_u;
            corner_uv[3] = vx.tex_v;
            corners_held = 2;
            return 0;
        end
        if (corners_held != 2) begin
            for (int k = 0; k < 3; k++) corner_pos[k] = p[k];
            corner_uv[0] = vx.tex_u;
            corner_uv[1] = vx.tex_v;
            corners_held = 1;
            return 0;
        end
        corners_held = 0;
        for (int k = 0; k < 3; k++) begin
            e1[k] = clip_edge(corner_pos[k], corner_pos[3+k]);
            e2[k] = clip_edge(corner_pos[k], p[k]);
        end
        s1 = clip_edge(corner_uv[0], corner_uv[2]);
        t1 = clip_edge(corner_uv[1], corner_uv[3]);
        s2 = clip_edge(corner_uv[0], vx.tex_u);
        t2 = clip_edge(corner_uv[1], vx.tex_v);
        det = s1 * t2 - t1 * s2;
        if (abs64(det) < abs64(eps)) det = eps;
        b_tiny = 1;
        c_tiny = 1;
        for (int k = 0; k < 3; k++) begin
            bv[k] = t1 * e2[k] - e1[k] * t2;
            cv[k] = e1[k] * s2 - s1 * e2[k];
            if (abs64(bv[k]) >= abs64(eps)) b_tiny = 0;
            if (abs64(cv[k]) >= abs64(eps)) c_tiny = 0;
        end
        for (int k = 0; k < 3; k++) begin
            if (b_tiny) bv[k] = eps;
            if (c_tiny) cv[k] = eps;
        end
        word[47:0]  = unit_dir(bv[0], bv[1], bv[2], det > 0);
        word[95:48] = unit_dir(cv[0], cv[1], cv[2], det > 0);
        return 1;
    endfunction

    function automatic t_vertex mk(logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z, logic signed [31:0] u,
                                   logic signed [31:0] v);
        t_vertex r;
        r.pos_x = x; r.pos_y = y; r.pos_z = z; r.tex_u = u; r.tex_v = v;
        return r;
    endfunction

    function automatic void add_row(t_vertex vx, bit typed = 0, logic [95:0] word = '0);
        t_row r;
        r.vtx = vx;
        r.typed = typed;
        r.word = word;
        plan.insert(plan.size(), r);
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 8191)) - 4096);
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            3: return $urandom_range(0, 1) ? PMax : NMax;
            default: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    // Present one vertex word; entered and left at a falling edge.
    task automatic send_vertex(t_row r, int gap);
        logic [95:0] word;
        bit          has;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = r.vtx;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        has = frame_predict(r.vtx, word);
        if (has) pending_frames.insert(pending_frames.size(), r.typed ? r.word : word);
        vertices_sent++;
        @(negedge i_clk);
    endtask

    // Output side: random stalls per word, with quiet stretches.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                stall--;
            end else begin
                m_axis_tready = 1'b1;
            end
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                stall = no_stall ? 0 : $urandom_range(0, 15);
        end
    end

    // Compare every output word against the oldest expected frame.
    always @(posedge i_clk) begin
        logic [95:0] exp_w;
        string       names[6];
        names = '{"tangent_x", "tangent_y", "tangent_z",
                  "binormal_x", "binormal_y", "binormal_z"};
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            frames_seen++;
            if (pending_frames.size() == 0) begin
                $error("output word with no frame expected: %h", m_axis_tdata);
                errors++;
            end else begin
                exp_w = pending_frames.pop_front();
                for (int k = 0; k < 6; k++) begin
                    if (m_axis_tdata[16*k +: 16] !== exp_w[16*k +: 16]) begin
                        $error("%s: expected %0d, got %0d", names[k],
                               $signed(exp_w[16*k +: 16]),
                               $signed(m_axis_tdata[16*k +: 16]));
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        logic [95:0] flat_word;
        int          waited;
        errors = 0;
        frames_seen = 0;
        vertices_sent = 0;
        corners_held = 0;
        no_stall = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // All corners equal: tiny determinant and tiny terms, all components -1/sqrt(3).
        flat_word = {6{16'shdb0d}};
        add_row(mk(0, 0, 0, 0, 0));
        add_row(mk(0, 0, 0, 0, 0));
        add_row(mk(0, 0, 0, 0, 0), 1, flat_word);
        // Regular triangle with positive determinant.
        add_row(mk(0, 0, 0, 0, 0));
        add_row(mk(32'sh10000, 0, 0, 32'sh10000, 0));
        add_row(mk(0, 32'sh10000, 0, 0, 32'sh10000));
        // Mirrored UV: negative determinant.
        add_row(mk(0, 0, 0, 0, 0));
        add_row(mk(32'sh10000, 0, 0, 0, 32'sh10000));
        add_row(mk(0, 32'sh10000, 0, 32'sh10000, 0));
        // Field extremes: edges between PMax and NMax saturate.
        add_row(mk(PMax, PMax, PMax, PMax, PMax));
        add_row(mk(NMax, NMax, NMax, NMax, NMax));
        add_row(mk(NMax, PMax, NMax, NMax, PMax));
        add_row(mk(NMax, NMax, NMax, NMax, NMax));
        add_row(mk(PMax, NMax, PMax, PMax, NMax));
        add_row(mk(PMax, PMax, NMax, NMax, PMax));
        // Degenerate UV but real positions: tiny determinant and tiny terms.
        add_row(mk(0, 0, 0, 5, 5));
        add_row(mk(32'sh30000, 32'sh10000, 0, 5, 5));
        add_row(mk(0, 32'sh20000, 32'sh10000, 5, 5));
        // Flat positions: both term vectors tiny, determinant not.
        add_row(mk(7, 7, 7, 0, 0));
        add_row(mk(7, 7, 7, 32'sh10000, 0));
        add_row(mk(7, 7, 7, 0, 32'sh10000));
        // Equal u makes the binormal terms and determinant tiny; collinear edges the tangent terms.
        add_row(mk(0, 0, 0, 0, 0));
        add_row(mk(32'sh10000, 32'sh20000, 0, 0, 32'sh10000));
        add_row(mk(32'sh20000, 32'sh40000, 0, 0, 32'sh20000));

        foreach (plan[i]) send_vertex(plan[i], $urandom_range(0, 15));

        // Hold off until every frame of the directed part has come out.
        s_axis_tvalid = 1'b0;
        while (pending_frames.size() != 0) @(negedge i_clk);

        for (int t = 0; t < NumRandTris; t++) begin
            t_row r;
            bit   quiet;
            quiet = (t % 40) >= 30;
            no_stall = quiet;
            for (int c = 0; c < 3; c++) begin
                r.vtx = mk(rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), rand_coord());
                r.typed = 0;
                r.word = '0;
                send_vertex(r, quiet ? 0 : $urandom_range(0, 15));
            end
        end
        s_axis_tvalid = 1'b0;

        waited = 0;
        while (pending_frames.size() != 0 && waited < 100000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (TailCycles) @(negedge i_clk);

        $display("Sent %0d vertices (%0d triangles incl. saturated, flat and degenerate UV cases),",
                 vertices_sent, vertices_sent / 3);
        $display("checked %0d frame words; %0d mismatches.", frames_seen, errors);
        if (errors == 0 && pending_frames.size() == 0) begin
            $display("tb_top passed");
        end else begin
            if (pending_frames.size() != 0)
                $error("%0d frames never came out", pending_frames.size());
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== triangle_tangent_binormal_unit.f =====
src/ttb_pkg.sv
src/ttb_alu.sv
src/triangle_tangent_binormal_unit.sv
dv/tb_top.sv
